FILE: sv/midi_controller_latch_unit_assert.svh
// ----------------------------------------------------------------------------
// midi controller latch unit: assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef MIDI_CONTROLLER_LATCH_UNIT_ASSERT_SVH
`define MIDI_CONTROLLER_LATCH_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define MCL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mcl_pkg.sv
// ----------------------------------------------------------------------------
// mcl_pkg
// sizes, codes, types and address helpers of the controller latch unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcl_pkg;

    localparam int NUM_CHANNELS    = 16;
    localparam int NUM_CONTROLLERS = 128;
    localparam int TABLE_DEPTH     = NUM_CHANNELS * NUM_CONTROLLERS;
    localparam int ADDR_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int CHAN_W  = 4;
    localparam int CTRL_W  = 7;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 7;
    localparam int ENTRY_W = VALUE_W + 1;

    localparam logic [KIND_W-1:0] KIND_NOTE_OFF    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_CTRL_CHANGE = 4'd11;

    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // one access to the table: a write port and a read address
    typedef struct packed {
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
        addr_t  rd_addr;
    } tbl_req_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               fresh;
    } res_t;

    function automatic addr_t entry_addr(input logic [CHAN_W-1:0] chan,
                                         input logic [CTRL_W-1:0] ctrl);
        int a;
        a = int'(chan) * NUM_CONTROLLERS + int'(ctrl);
        return addr_t'(a);
    endfunction

    function automatic logic chan_ok(input logic [CHAN_W-1:0] chan);
        return int'(chan) < NUM_CHANNELS;
    endfunction

    function automatic logic ctrl_ok(input logic [CTRL_W-1:0] ctrl);
        return int'(ctrl) < NUM_CONTROLLERS;
    endfunction

endpackage

FILE: sv/mcl_table.sv
// ----------------------------------------------------------------------------
// mcl_table
// entry table memory: one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcl_table (
    input  logic              clk,
    input  mcl_pkg::tbl_req_t req,
    output mcl_pkg::entry_t   rd_data
);

    mcl_pkg::entry_t mem [mcl_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

FILE: sv/mcl_ctrl.sv
// ----------------------------------------------------------------------------
// mcl_ctrl
// sequencer: clearing sweep, message decode and the channel scan of reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcl_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               cmd,
    input  logic [mcl_pkg::KIND_W-1:0]         msg_kind,
    input  logic [mcl_pkg::CHAN_W-1:0]         channel,
    input  logic                               any_channel,
    input  logic [mcl_pkg::CTRL_W-1:0]         controller,
    input  logic [mcl_pkg::VALUE_W-1:0]        data_value,
    input  mcl_pkg::entry_t                    rd_data,
    output mcl_pkg::tbl_req_t                  req,
    output mcl_pkg::res_t                      res,
    output logic                               busy
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;
    localparam logic [1:0] ST_SCAN   = 2'd3;

    localparam logic [mcl_pkg::CHAN_W-1:0] LAST_CHAN =
        mcl_pkg::CHAN_W'(mcl_pkg::NUM_CHANNELS - 1);
    localparam mcl_pkg::addr_t LAST_ADDR = mcl_pkg::addr_t'(mcl_pkg::TABLE_DEPTH - 1);

    logic [1:0]                     state_reg, state_next;
    mcl_pkg::addr_t                 clr_cnt_reg, clr_cnt_next;
    logic [mcl_pkg::CHAN_W-1:0]     scan_reg, scan_next;

    logic                           cmd_reg;
    logic [mcl_pkg::KIND_W-1:0]     kind_reg;
    logic [mcl_pkg::CHAN_W-1:0]     chan_reg;
    logic                           any_reg;
    logic [mcl_pkg::CTRL_W-1:0]     ctrl_reg;
    logic [mcl_pkg::VALUE_W-1:0]    val_reg;

    logic                           accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            kind_reg <= msg_kind;
            chan_reg <= channel;
            any_reg  <= any_channel;
            ctrl_reg <= controller;
            val_reg  <= data_value;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        scan_next    = scan_reg;
        req.wr_en    = 1'b0;
        req.wr_addr  = mcl_pkg::entry_addr(scan_reg, ctrl_reg);
        req.wr_data  = '0;
        res          = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (cmd_reg == mcl_pkg::CMD_MSG)
                begin
                    if (mcl_pkg::chan_ok(chan_reg) && mcl_pkg::ctrl_ok(ctrl_reg))
                    begin
                        req.wr_addr = mcl_pkg::entry_addr(chan_reg, ctrl_reg);
                        unique case (kind_reg) inside
                            mcl_pkg::KIND_CTRL_CHANGE, mcl_pkg::KIND_NOTE_ON:
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_data = {1'b1, val_reg};
                            end
                            mcl_pkg::KIND_NOTE_OFF:
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_data = {1'b1, {mcl_pkg::VALUE_W{1'b0}}};
                            end
                            default:
                            begin
                                req.wr_en = 1'b0;
                            end
                        endcase
                    end
                end
                else if (!mcl_pkg::ctrl_ok(ctrl_reg) ||
                         (!any_reg && !mcl_pkg::chan_ok(chan_reg)))
                begin
                    res.valid = 1'b1;
                end
                else
                begin
                    scan_next  = any_reg ? '0 : chan_reg;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the entry of scan_reg
                if (!any_reg || rd_data[mcl_pkg::VALUE_W])
                begin
                    res.valid   = 1'b1;
                    res.value   = rd_data[mcl_pkg::VALUE_W-1:0];
                    res.fresh   = rd_data[mcl_pkg::VALUE_W];
                    req.wr_en   = 1'b1;
                    req.wr_data = {1'b0, rd_data[mcl_pkg::VALUE_W-1:0]};
                    state_next  = ST_IDLE;
                end
                else if (scan_reg == LAST_CHAN)
                begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // next channel's entry is fetched while the current one is checked
        req.rd_addr = mcl_pkg::entry_addr(scan_next, ctrl_reg);
    end

endmodule

FILE: sv/midi_controller_latch_unit.sv
// ----------------------------------------------------------------------------
// midi_controller_latch_unit
// latch table of midi controller and note values, 16 channels x 128 entries
// ----------------------------------------------------------------------------
// After reset the unit holds busy high while it sweeps the table to zero, one
// entry per cycle. An item is taken when start is high and busy is low. A
// message item keeps busy high while it is decoded and gives no result. A read
// of one channel checks that channel's entry; an any-channel read walks the
// channels through the single table read port, one channel per cycle, until it
// finds a fresh entry or has checked the last channel. Each result beat shows
// on ctrl_value and fresh for exactly one cycle with done high, and must be
// taken then: the receiver cannot stall.
`timescale 1ns / 1ps

`include "midi_controller_latch_unit_assert.svh"

module midi_controller_latch_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [mcl_pkg::KIND_W-1:0]   msg_kind,
    input  logic [mcl_pkg::CHAN_W-1:0]   channel,
    input  logic                         any_channel,
    input  logic [mcl_pkg::CTRL_W-1:0]   controller,
    input  logic [mcl_pkg::VALUE_W-1:0]  data_value,
    output logic                         done,
    output logic [mcl_pkg::VALUE_W-1:0]  ctrl_value,
    output logic                         fresh
);

    mcl_pkg::tbl_req_t            tbl_req;
    mcl_pkg::entry_t              rd_data;
    mcl_pkg::res_t                res;

    logic                         done_reg;
    logic [mcl_pkg::VALUE_W-1:0]  value_reg;
    logic                         fresh_reg;

    mcl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .msg_kind    (msg_kind),
        .channel     (channel),
        .any_channel (any_channel),
        .controller  (controller),
        .data_value  (data_value),
        .rd_data     (rd_data),
        .req         (tbl_req),
        .res         (res),
        .busy        (busy)
    );

    mcl_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            value_reg <= res.value;
            fresh_reg <= res.fresh;
        end
    end

    assign done       = done_reg;
    assign ctrl_value = value_reg;
    assign fresh      = fresh_reg;

    `MCL_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result beat without work in flight")
    `MCL_ASSERT_NEXT(a_msg_no_result, start && !busy && (cmd == mcl_pkg::CMD_MSG), !done ##1 !done, "message item produced a result beat")
    `MCL_ASSERT_SAME(a_no_write_idle, !busy, !tbl_req.wr_en, "table written while idle")

endmodule
